@@ rtl/tkbd_pkg.sv @@
// Shared types and constants of the touch key baseline decider.
package tkbd_pkg;

  localparam int DATA_W    = 16;
  localparam int CH_NUM    = 7;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_THR_MIDDLE     = 3'd0;
  localparam cfg_idx_t CFG_THR_UP         = 3'd1;
  localparam cfg_idx_t CFG_THR_DOWN       = 3'd2;
  localparam cfg_idx_t CFG_THR_LEFT       = 3'd3;
  localparam cfg_idx_t CFG_THR_RIGHT      = 3'd4;
  localparam cfg_idx_t CFG_THR_DIAG_LEFT  = 3'd5;
  localparam cfg_idx_t CFG_THR_DIAG_RIGHT = 3'd6;
  localparam cfg_idx_t CFG_DOM_MARGIN     = 3'd7;

  localparam logic [DATA_W-1:0] RST_THR_MIDDLE     = 16'h01B0;
  localparam logic [DATA_W-1:0] RST_THR_UP         = 16'h0180;
  localparam logic [DATA_W-1:0] RST_THR_DOWN       = 16'h0230;
  localparam logic [DATA_W-1:0] RST_THR_LEFT       = 16'h0590;
  localparam logic [DATA_W-1:0] RST_THR_RIGHT      = 16'h0590;
  localparam logic [DATA_W-1:0] RST_THR_DIAG_LEFT  = 16'h0300;
  localparam logic [DATA_W-1:0] RST_THR_DIAG_RIGHT = 16'h00A0;
  localparam logic [DATA_W-1:0] RST_DOM_MARGIN     = 16'd50;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  localparam int CH_MIDDLE     = 0;
  localparam int CH_DOWN       = 1;
  localparam int CH_UP         = 2;
  localparam int CH_LEFT       = 3;
  localparam int CH_RIGHT      = 4;
  localparam int CH_DIAG_LEFT  = 5;
  localparam int CH_DIAG_RIGHT = 6;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] count_middle;
    logic [DATA_W-1:0] count_down;
    logic [DATA_W-1:0] count_up;
    logic [DATA_W-1:0] count_left;
    logic [DATA_W-1:0] count_right;
    logic [DATA_W-1:0] count_diag_left;
    logic [DATA_W-1:0] count_diag_right;
  } in_item_t;

  typedef struct packed {
    logic              led_on;
    logic [DATA_W-1:0] delta_middle;
    logic [DATA_W-1:0] delta_down;
    logic [DATA_W-1:0] delta_up;
    logic [DATA_W-1:0] delta_left;
    logic [DATA_W-1:0] delta_right;
    logic [DATA_W-1:0] delta_diag_left;
    logic [DATA_W-1:0] delta_diag_right;
  } out_item_t;

  typedef struct packed {
    cfg_idx_t          index;
    logic [DATA_W-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] thr_middle;
    logic [DATA_W-1:0] thr_up;
    logic [DATA_W-1:0] thr_down;
    logic [DATA_W-1:0] thr_left;
    logic [DATA_W-1:0] thr_right;
    logic [DATA_W-1:0] thr_diag_left;
    logic [DATA_W-1:0] thr_diag_right;
    logic [DATA_W-1:0] dominance_margin;
  } thr_t;

  typedef struct packed {
    logic load;
    logic measure;
    logic decrement;
  } lane_ctrl_t;

  typedef struct packed {
    logic led_on;
    logic idle;
  } decision_t;

endpackage

@@ rtl/tkbd_stream_if.sv @@
// Valid/ready channel interface carrying one payload item per transfer.
interface tkbd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tkbd_lane.sv @@
// One key channel: baseline register, delta and baseline tracking.
module tkbd_lane #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [COUNT_BITS-1:0]  count,
  input  tkbd_pkg::lane_ctrl_t   ctrl,
  output logic [COUNT_BITS-1:0]  delta,
  output logic [COUNT_BITS-1:0]  base
);
  import tkbd_pkg::*;

  logic                  above;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] tracked;
  logic [COUNT_BITS-1:0] tracked_dec;
  logic [COUNT_BITS-1:0] base_next;

  assign above       = count > base;
  assign sum         = {1'b0, base} + {1'b0, count};
  assign tracked     = above ? sum[COUNT_BITS:1] : base;
  assign tracked_dec = (tracked != '0) ? tracked - 1'b1 : tracked;
  assign delta       = above ? '0 : base - count;

  always_comb begin
    base_next = base;
    if (ctrl.load) begin
      base_next = count;
    end else if (ctrl.measure) begin
      base_next = ctrl.decrement ? tracked_dec : tracked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else begin
      base <= base_next;
    end
  end
endmodule

@@ rtl/tkbd_decide.sv @@
// Merge stage: threshold rules over the seven deltas decide LED and idle.
module tkbd_decide (
  input  logic [tkbd_pkg::CH_NUM-1:0][tkbd_pkg::DATA_W-1:0] delta,
  input  tkbd_pkg::thr_t                                    thr,
  output tkbd_pkg::decision_t                               decision
);
  import tkbd_pkg::*;

  logic              other_key;
  logic              blocking_key;
  logic              middle_dominant;
  logic              press_test;
  logic              press;
  logic [DATA_W:0]   middle_sum;

  assign middle_sum = {1'b0, delta[CH_MIDDLE]} + {1'b0, thr.dominance_margin};

  assign blocking_key = (delta[CH_UP] > thr.thr_up) || (delta[CH_LEFT] > thr.thr_left) ||
                        (delta[CH_RIGHT] > thr.thr_right);

  assign other_key = blocking_key || (delta[CH_DOWN] > thr.thr_down) ||
                     (delta[CH_DIAG_LEFT] > thr.thr_diag_left) ||
                     (delta[CH_DIAG_RIGHT] > thr.thr_diag_right);

  assign middle_dominant = (middle_sum > {1'b0, delta[CH_DOWN]}) &&
                           (delta[CH_MIDDLE] > thr.thr_middle);

  assign press_test = !other_key || (!blocking_key && middle_dominant);

  assign press = ((delta[CH_MIDDLE] > thr.thr_middle) && (delta[CH_DOWN] < thr.thr_down) &&
                  (delta[CH_UP] < thr.thr_up) && (delta[CH_LEFT] < thr.thr_left) &&
                  (delta[CH_RIGHT] < thr.thr_right)) ||
                 ((delta[CH_MIDDLE] > delta[CH_DOWN]) &&
                  (delta[CH_MIDDLE] > thr.thr_middle));

  assign decision.led_on = press_test && press;
  assign decision.idle   = press_test && !press;
endmodule

@@ rtl/touch_key_baseline_decider.sv @@
// Top level of the seven-channel touch key baseline tracker and middle-key decider.
// The block takes one set of counts per clock cycle unless the skid register
// is full. Each transfer is evaluated in the cycle it is accepted: seven lanes
// form their deltas from the stored baselines, the decision stage applies the
// threshold rules, and the baselines are updated at the same clock edge, so the
// next set sees them. The result is registered in the output register; a skid
// register behind it lets the input side accept one more set while a result is
// stalled. Configuration writes take effect at the next cycle and are always
// accepted.
module touch_key_baseline_decider #(
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  tkbd_stream_if.sink          item,
  tkbd_stream_if.source        result,
  tkbd_stream_if.sink          cfg
);
  import tkbd_pkg::*;

  thr_t                                thr;
  logic [CH_NUM-1:0][COUNT_BITS-1:0]   cnt;
  logic [CH_NUM-1:0][COUNT_BITS-1:0]   lane_delta;
  logic [CH_NUM-1:0][COUNT_BITS-1:0]   base;
  logic [CH_NUM-1:0][DATA_W-1:0]       delta;
  lane_ctrl_t                          ctrl;
  decision_t                           decision;
  logic                                accept;
  logic                                measure;
  out_item_t                           res_next;
  out_item_t                           out_data;
  out_item_t                           skid_data;
  logic                                out_valid;
  logic                                skid_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.thr_middle       <= RST_THR_MIDDLE;
      thr.thr_up           <= RST_THR_UP;
      thr.thr_down         <= RST_THR_DOWN;
      thr.thr_left         <= RST_THR_LEFT;
      thr.thr_right        <= RST_THR_RIGHT;
      thr.thr_diag_left    <= RST_THR_DIAG_LEFT;
      thr.thr_diag_right   <= RST_THR_DIAG_RIGHT;
      thr.dominance_margin <= RST_DOM_MARGIN;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        CFG_THR_MIDDLE:     thr.thr_middle       <= cfg.data.data;
        CFG_THR_UP:         thr.thr_up           <= cfg.data.data;
        CFG_THR_DOWN:       thr.thr_down         <= cfg.data.data;
        CFG_THR_LEFT:       thr.thr_left         <= cfg.data.data;
        CFG_THR_RIGHT:      thr.thr_right        <= cfg.data.data;
        CFG_THR_DIAG_LEFT:  thr.thr_diag_left    <= cfg.data.data;
        CFG_THR_DIAG_RIGHT: thr.thr_diag_right   <= cfg.data.data;
        CFG_DOM_MARGIN:     thr.dominance_margin <= cfg.data.data;
        default: ;
      endcase
    end
  end

  assign item.ready = !skid_valid;
  assign accept     = item.valid && item.ready;
  assign measure    = (item.data.mode == MODE_MEASURE);

  assign cnt[CH_MIDDLE]     = item.data.count_middle[COUNT_BITS-1:0];
  assign cnt[CH_DOWN]       = item.data.count_down[COUNT_BITS-1:0];
  assign cnt[CH_UP]         = item.data.count_up[COUNT_BITS-1:0];
  assign cnt[CH_LEFT]       = item.data.count_left[COUNT_BITS-1:0];
  assign cnt[CH_RIGHT]      = item.data.count_right[COUNT_BITS-1:0];
  assign cnt[CH_DIAG_LEFT]  = item.data.count_diag_left[COUNT_BITS-1:0];
  assign cnt[CH_DIAG_RIGHT] = item.data.count_diag_right[COUNT_BITS-1:0];

  assign ctrl.load      = accept && !measure;
  assign ctrl.measure   = accept && measure;
  assign ctrl.decrement = decision.idle;

  for (genvar i = 0; i < CH_NUM; i++) begin : g_lane
    tkbd_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .count (cnt[i]),
      .ctrl  (ctrl),
      .delta (lane_delta[i]),
      .base  (base[i])
    );
    assign delta[i] = DATA_W'(lane_delta[i]);
  end

  tkbd_decide u_decide (
    .delta    (delta),
    .thr      (thr),
    .decision (decision)
  );

  always_comb begin
    res_next = '0;
    if (measure) begin
      res_next.led_on           = decision.led_on;
      res_next.delta_middle     = delta[CH_MIDDLE];
      res_next.delta_down       = delta[CH_DOWN];
      res_next.delta_up         = delta[CH_UP];
      res_next.delta_left       = delta[CH_LEFT];
      res_next.delta_right      = delta[CH_RIGHT];
      res_next.delta_diag_left  = delta[CH_DIAG_LEFT];
      res_next.delta_diag_right = delta[CH_DIAG_RIGHT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result.ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : res_next;
    end else if (accept) begin
      skid_data <= res_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // The skid register only fills behind a stalled result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !result.ready))
    else $error("skid register filled without a stalled output");

  a_load_sets_baseline: assert property (@(posedge clk) disable iff (rst)
    (accept && !measure) |=> base[CH_MIDDLE] == $past(cnt[CH_MIDDLE]))
    else $error("load transfer did not set the middle baseline");

  a_led_needs_delta: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.led_on) |-> (out_data.delta_middle != '0))
    else $error("LED on with a zero middle delta");
endmodule
